FILE: sv/radix_integer_to_ascii_macros.svh
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_macros: assertion macros
// Shared concurrent assertion forms for the converter's modules.
// ----------------------------------------------------------------------------
`ifndef RADIX_INTEGER_TO_ASCII_MACROS_SVH
`define RADIX_INTEGER_TO_ASCII_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RI2A_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RI2A_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ri2a_pkg.sv
// ----------------------------------------------------------------------------
// ri2a_pkg
// Word types, character constants and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ri2a_pkg;

  localparam int IN_VALUE_W = 32;
  localparam int RADIX_W    = 5;
  localparam int CHAR_W     = 7;
  localparam int DIGIT_W    = 4;
  // Dividend bits consumed per divider cycle.
  localparam int CHUNK      = 8;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS   = 7'h2D;
  localparam logic [RADIX_W-1:0] RADIX_MIN    = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX    = 5'd16;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN    = 4'd10;

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic [RADIX_W-1:0]    radix;
    logic                  mode;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_word_t;

  typedef enum logic [1:0] {
    SEL_MINUS,
    SEL_ZERO,
    SEL_DIGIT
  } out_sel_t;

  typedef struct packed {
    logic     load;      // capture a new input word
    logic     step;      // one divider cycle
    logic     fetch;     // read the next stored digit, most significant first
    logic     out_load;  // fill the output register
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic at_digit;   // divider sits at a digit boundary
    logic q_zero;     // running quotient is zero
    logic cnt_zero;   // no digits stored
    logic neg;        // signed conversion of a negative value
    logic last_pend;  // fetched digit is the final character
  } status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_LOWER_A + CHAR_W'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/ri2a_ctrl.sv
// ----------------------------------------------------------------------------
// ri2a_ctrl
// Sequencer: division loop, optional sign, then digit emission.
// ----------------------------------------------------------------------------
`default_nettype none
`include "radix_integer_to_ascii_macros.svh"

module ri2a_ctrl
  import ri2a_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  typedef enum logic [2:0] {
    IDLE,
    DIVIDE,
    MINUS,
    ZERO,
    FETCH,
    LOAD
  } state_t;

  state_t state, state_next;
  logic   out_free;

  // The output register may be refilled when empty or being taken this cycle.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = DIVIDE;
        end
      end
      DIVIDE: begin
        if (st.at_digit && st.q_zero) begin
          if (st.cnt_zero) begin
            state_next = ZERO;
          end else if (st.neg) begin
            state_next = MINUS;
          end else begin
            state_next = FETCH;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      MINUS: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_MINUS;
          state_next   = FETCH;
        end
      end
      ZERO: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_ZERO;
          state_next   = IDLE;
        end
      end
      FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = LOAD;
      end
      LOAD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_DIGIT;
          state_next   = st.last_pend ? IDLE : FETCH;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `RI2A_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.out_load, !out_valid || out_ready,
                   "output word overwritten before it was taken")
  `RI2A_ASSERT_NXT(a_accept_divides, clk, rst, in_valid && in_ready, state == DIVIDE,
                   "accepted word did not start the division")
  `RI2A_ASSERT_NOW(a_fetch_has_digit, clk, rst, cmd.fetch, !st.cnt_zero,
                   "digit fetch with an empty digit store")

endmodule

`default_nettype wire

FILE: sv/ri2a_dp.sv
// ----------------------------------------------------------------------------
// ri2a_dp
// Datapath: magnitude, chunked radix divider, digit store and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "radix_integer_to_ascii_macros.svh"

module ri2a_dp
  import ri2a_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_word_t in_word,
  input  wire cmd_t     cmd,
  output status_t       st,
  output out_word_t     out_word
);

  localparam int DIV_CYC = (VALUE_WIDTH + CHUNK - 1) / CHUNK;
  localparam int DIV_W   = DIV_CYC * CHUNK;
  localparam int CH_W    = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam int CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_W   = $clog2(VALUE_WIDTH);

  logic [DIV_W-1:0]   work;      // running quotient, shifted through the divider
  logic [DIGIT_W-1:0] rem;
  logic [RADIX_W-1:0] radix_r;
  logic               neg;
  logic [CH_W-1:0]    chunk;
  logic [CNT_W-1:0]   cnt;
  logic               last_pend;
  logic [DIGIT_W-1:0] rd_digit;

  logic [DIGIT_W-1:0] digit_store [VALUE_WIDTH];

  // Input capture.
  logic [63:0]          val_ext;
  logic [VALUE_WIDTH-1:0] v;
  logic [VALUE_WIDTH-1:0] v_neg;
  logic                 neg_in;
  logic [RADIX_W-1:0]   radix_in;

  assign val_ext = 64'(in_word.value);
  assign v       = val_ext[VALUE_WIDTH-1:0];
  assign v_neg   = ~v + VALUE_WIDTH'(1);
  assign neg_in  = in_word.mode && v[VALUE_WIDTH-1];

  always_comb begin
    if (in_word.radix < RADIX_MIN) begin
      radix_in = RADIX_MIN;
    end else if (in_word.radix > RADIX_MAX) begin
      radix_in = RADIX_MAX;
    end else begin
      radix_in = in_word.radix;
    end
  end

  // One divider cycle: CHUNK restoring steps on a 5-bit partial remainder.
  logic [CHUNK-1:0]   qbits;
  logic [DIGIT_W-1:0] rem_next;
  logic [DIV_W-1:0]   work_next;
  logic               chunk_last;

  always_comb begin
    logic [DIGIT_W:0]   t;
    logic [DIGIT_W-1:0] r;
    r     = rem;
    qbits = '0;
    for (int i = 0; i < CHUNK; i++) begin
      t = {r, work[DIV_W-1-i]};
      if (t >= radix_r) begin
        t                  = t - radix_r;
        qbits[CHUNK-1-i]   = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_next  = r;
    work_next = (work << CHUNK) | DIV_W'(qbits);
  end

  assign chunk_last = (chunk == CH_W'(DIV_CYC - 1));

  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;

  assign cnt_m1  = cnt - CNT_W'(1);
  assign rd_addr = cnt_m1[IDX_W-1:0];
  assign wr_addr = cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      work      <= '0;
      neg       <= 1'b0;
      chunk     <= '0;
      cnt       <= '0;
      last_pend <= 1'b0;
    end else begin
      if (cmd.load) begin
        work  <= DIV_W'(neg_in ? v_neg : v);
        neg   <= neg_in;
        chunk <= '0;
        cnt   <= '0;
      end else if (cmd.step) begin
        work  <= work_next;
        chunk <= chunk_last ? '0 : chunk + CH_W'(1);
        if (chunk_last) begin
          cnt <= cnt + CNT_W'(1);
        end
      end else if (cmd.fetch) begin
        cnt       <= cnt_m1;
        last_pend <= (cnt == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      radix_r <= radix_in;
      rem     <= '0;
    end else if (cmd.step) begin
      rem <= chunk_last ? '0 : rem_next;
    end
  end

  // Digit store: written at the digit count, read back in reverse order.
  always_ff @(posedge clk) begin
    if (cmd.step && chunk_last) begin
      digit_store[wr_addr] <= rem_next;
    end
    if (cmd.fetch) begin
      rd_digit <= digit_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.out_sel)
        SEL_MINUS: out_word <= '{character: CHAR_MINUS, last: 1'b0};
        SEL_ZERO:  out_word <= '{character: CHAR_ZERO, last: 1'b1};
        SEL_DIGIT: out_word <= '{character: digit_char(rd_digit), last: last_pend};
        default:   out_word <= '{character: CHAR_ZERO, last: 1'b1};
      endcase
    end
  end

  assign st.at_digit  = (chunk == '0);
  assign st.q_zero    = (work == '0);
  assign st.cnt_zero  = (cnt == '0);
  assign st.neg       = neg;
  assign st.last_pend = last_pend;

  `RI2A_ASSERT_NOW(a_store_in_range, clk, rst, cmd.step && chunk_last,
                   cnt < CNT_W'(VALUE_WIDTH), "digit write beyond the digit store")
  `RI2A_ASSERT_NOW(a_rem_below_radix, clk, rst, cmd.step,
                   {1'b0, rem_next} < radix_r, "remainder not below the radix")

endmodule

`default_nettype wire

FILE: sv/radix_integer_to_ascii.sv
// ----------------------------------------------------------------------------
// radix_integer_to_ascii
// Division: each digit takes a full pass of the 8-bit-per-cycle radix divider
//   over the dividend.
// Each character is then read from the digit store and loaded into the output
//   register; a '-' needs only the output load. One word at a time.
// Reset (rst, synchronous) returns the sequencer to idle and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_integer_to_ascii
  import ri2a_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_word,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_word_t     out_word
);

  // The controller steps the datapath through three phases. The divide phase
  // repeatedly divides the magnitude by the clamped radix, storing one digit
  // (least significant first) each time the divider finishes a pass over the
  // dividend. The sign phase emits a minus sign for negative signed words. The
  // emit phase reads the digit store from the top down and converts each digit
  // to '0'..'9' or 'a'..'f'. A zero word skips straight to a single '0'.
  //
  // The output word sits in a register, so the next input word can be taken
  // while the final character of the previous one is still waiting.

  cmd_t    cmd;
  status_t st;

  ri2a_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  ri2a_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_word),
    .cmd      (cmd),
    .st       (st),
    .out_word (out_word)
  );

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: radix integer-to-ASCII converter testbench
// Sends conversion words (value, radix, signed mode) and checks each returned
// character word against a local model of the digit conversion. A short table
// of directed cases covers zero, the largest and most negative values, letter
// digits in several radixes and radix clamping. Random words follow in three
// phases of flow control: sender idles lightly and receiver heavily, then the
// reverse, then neither side idles.
// ----------------------------------------------------------------------------

module tb;
  import ri2a_pkg::*;

  localparam int VALUE_WIDTH      = 32;
  localparam int DIRECTED_ROWS    = 25;
  localparam int RANDOM_PER_PHASE = 58;
  // Worst case word is 33 characters; allow time for one after the last
  // expected character to catch anything extra.
  localparam int DRAIN_CYCLES     = 250;
  localparam int TIMEOUT_NS       = 4_000_000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  // Flow control knobs, in percent of cycles spent idle. The stimulus
  // process changes them at phase boundaries.
  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 58;

  int unsigned mismatches = 0;

  // Characters still owed by the converter, oldest first.
  out_word_t pending_chars[$];

  radix_integer_to_ascii #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Directed table. A non-empty text column is the exact expected character
  // string; an empty one means the expected characters come from the model
  // below. Radix 0, 1, 17 and 31 check clamping to the 2..16 range.
  in_word_t directed_words [DIRECTED_ROWS] = '{
    '{32'h0000_0000, 5'd10, 1'b0},
    '{32'h0000_0000, 5'd10, 1'b1},
    '{32'hFFFF_FFFF, 5'd16, 1'b0},
    '{32'hFFFF_FFFF, 5'd16, 1'b1},
    '{32'hFFFF_FFFF, 5'd2,  1'b0},
    '{32'hFFFF_FFFF, 5'd10, 1'b0},
    '{32'h8000_0000, 5'd16, 1'b1},
    '{32'h8000_0000, 5'd10, 1'b1},
    '{32'h8000_0000, 5'd2,  1'b1},
    '{32'h8000_0000, 5'd2,  1'b0},
    '{32'h7FFF_FFFF, 5'd16, 1'b1},
    '{32'h0000_000F, 5'd16, 1'b0},
    '{32'h0000_000A, 5'd11, 1'b0},
    '{32'h0000_000E, 5'd15, 1'b0},
    '{32'h0000_000F, 5'd0,  1'b0},
    '{32'h0000_0005, 5'd1,  1'b1},
    '{32'h0000_00FF, 5'd31, 1'b0},
    '{32'h0000_00FF, 5'd17, 1'b1},
    '{32'h0000_0009, 5'd10, 1'b0},
    '{32'h0000_000A, 5'd10, 1'b0},
    '{32'hDEAD_BEEF, 5'd16, 1'b0},
    '{32'h1234_5678, 5'd7,  1'b1},
    '{32'hFFFF_FFF6, 5'd10, 1'b1},
    '{32'h0000_0010, 5'd3,  1'b0},
    '{32'hFFFF_FFFF, 5'd3,  1'b1}
  };

  string directed_texts [DIRECTED_ROWS] = '{
    "0",
    "0",
    "ffffffff",
    "-1",
    "",
    "4294967295",
    "-80000000",
    "-2147483648",
    "",
    "",
    "7fffffff",
    "f",
    "a",
    "e",
    "1111",
    "101",
    "ff",
    "ff",
    "9",
    "10",
    "deadbeef",
    "",
    "-10",
    "",
    "-1"
  };

  // Works out the characters one conversion word should produce and queues
  // them. Digits come out least significant first from the division loop, so
  // they are queued in reverse, with the sign ahead of them.
  function automatic void predict_ascii(in_word_t w);
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [RADIX_W-1:0]     base;
    logic                   negative;
    logic [DIGIT_W-1:0]     digits [VALUE_WIDTH];
    int                     count;
    out_word_t              ch;
    base = w.radix;
    if (base < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (base > RADIX_MAX) begin
      base = RADIX_MAX;
    end
    magnitude = w.value[VALUE_WIDTH-1:0];
    negative  = w.mode && magnitude[VALUE_WIDTH-1];
    // The most negative value negates to itself, which read as unsigned is
    // exactly the magnitude we want.
    if (negative) begin
      magnitude = -magnitude;
    end
    if (magnitude == '0) begin
      ch.character = CHAR_ZERO;
      ch.last      = 1'b1;
      pending_chars.push_back(ch);
      return;
    end
    count = 0;
    while (magnitude != '0) begin
      digits[count] = DIGIT_W'(magnitude % base);
      magnitude     = magnitude / base;
      count++;
    end
    if (negative) begin
      ch.character = CHAR_MINUS;
      ch.last      = 1'b0;
      pending_chars.push_back(ch);
    end
    for (int i = count - 1; i >= 0; i--) begin
      if (digits[i] < 4'd10) begin
        ch.character = CHAR_ZERO + CHAR_W'(digits[i]);
      end else begin
        ch.character = CHAR_LOWER_A + CHAR_W'(digits[i] - 4'd10);
      end
      ch.last = (i == 0);
      pending_chars.push_back(ch);
    end
  endfunction

  // Queues a literal character string, marking the final character as last.
  function automatic void expect_text(string text);
    out_word_t ch;
    byte       c;
    for (int i = 0; i < text.len(); i++) begin
      c            = text[i];
      ch.character = c[CHAR_W-1:0];
      ch.last      = (i == text.len() - 1);
      pending_chars.push_back(ch);
    end
  endfunction

  // Random conversion words. Most radixes are legal; the rest cover the full
  // 5-bit field so clamping is hit from both sides. Values mix fully random
  // bits with short numbers, boundary values, powers of two and small
  // negatives, so that short and long digit strings both show up.
  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned kind;
    kind = $urandom_range(9);
    case (kind) inside
      4: begin
        w.value = $urandom_range(40);
      end
      5: begin
        case ($urandom_range(4))
          0:       w.value = 32'h8000_0000;
          1:       w.value = 32'h7FFF_FFFF;
          2:       w.value = 32'hFFFF_FFFF;
          3:       w.value = 32'h8000_0001;
          default: w.value = 32'h0000_0001;
        endcase
      end
      6: begin
        w.value = (32'h1 << $urandom_range(31)) - $urandom_range(1);
      end
      7: begin
        w.value = -$urandom_range(1, 100);
      end
      8, 9: begin
        w.value = $urandom >> $urandom_range(31);
      end
      default: begin
        w.value = $urandom;
      end
    endcase
    if ($urandom_range(9) == 0) begin
      w.radix = RADIX_W'($urandom_range(31));
    end else begin
      w.radix = RADIX_W'($urandom_range(16, 2));
    end
    w.mode = 1'($urandom_range(1));
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Offers one word to the converter. Entered and left at a falling edge.
  // Idle cycles are drawn first; once valid rises it stays up with a steady
  // payload until the word is taken, and the expectation is queued at the
  // very edge that accepts it.
  task automatic send_word(in_word_t w, string text);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(posedge clk);
    end while (!in_ready);
    if (text.len() > 0) begin
      expect_text(text);
    end else begin
      predict_ascii(w);
    end
    @(negedge clk);
  endtask

  // Holds the sender back until every owed character has come out. Valid is
  // dropped first and stays low until any later word raises it again.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_chars.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Receiver: decides ready for the next edge at every falling edge.
  initial begin
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Checker: every character word the converter hands over is compared with
  // the oldest expectation, field by field.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("character %h with nothing expected",
                                  out_word.character));
      end else begin
        want = pending_chars.pop_front();
        if (out_word.character !== want.character) begin
          report_mismatch($sformatf("character %h, expected %h",
                                    out_word.character, want.character));
        end
        if (out_word.last !== want.last) begin
          report_mismatch($sformatf("last %b, expected %b on character %h",
                                    out_word.last, want.last, want.character));
        end
      end
    end
  end

  // Stimulus: reset, directed table, then three phases of random words.
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Phase one: light sender gaps, heavy receiver stalls.
    send_idle_pct = 16;
    recv_idle_pct = 58;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_word(directed_words[i], directed_texts[i]);
    end
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      send_word(random_word(), "");
    end
    wait_drained();

    // Phase two: the reverse. An occasional full drain mid-phase lets the
    // converter go idle with a word arriving right after.
    send_idle_pct = 58;
    recv_idle_pct = 16;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      if ($urandom_range(15) == 0) begin
        wait_drained();
      end
      send_word(random_word(), "");
    end
    wait_drained();

    // Phase three: back-to-back words, receiver always ready.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      send_word(random_word(), "");
    end
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("[radix_integer_to_ascii] OK");
    end else begin
      $display("[radix_integer_to_ascii] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d characters outstanding", pending_chars.size());
    $display("[radix_integer_to_ascii] ERROR");
    $finish;
  end

endmodule
